// ===== sv/am2d_pkg.sv =====
// ----------------------------------------------------------------------------
// am2d_pkg: shared types and constants of the 2D affine matrix stack
// Command codes, status codes, sequencer states, CORDIC table and sizes.
// ----------------------------------------------------------------------------
package am2d_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned CORDIC_STEPS = 18;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] DEG_360 = 32'sd23592960;
  localparam logic signed [31:0] DEG_180 = 32'sd11796480;
  localparam logic signed [31:0] DEG_90 = 32'sd5898240;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [2:0] {
    FUNC_PUSH  = 3'd0,
    FUNC_POP   = 3'd1,
    FUNC_TRANS = 3'd2,
    FUNC_ROT   = 3'd3,
    FUNC_SCALE = 3'd4,
    FUNC_RESET = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RED0, S_RED1, S_CORDIC, S_MUL, S_MEMW, S_MEMR, S_MEMR2, S_OUT
  } state_e;

  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0: atan_deg = 32'sd2949120;
      5'd1: atan_deg = 32'sd1740967;
      5'd2: atan_deg = 32'sd919879;
      5'd3: atan_deg = 32'sd466945;
      5'd4: atan_deg = 32'sd234379;
      5'd5: atan_deg = 32'sd117304;
      5'd6: atan_deg = 32'sd58666;
      5'd7: atan_deg = 32'sd29335;
      5'd8: atan_deg = 32'sd14668;
      5'd9: atan_deg = 32'sd7334;
      5'd10: atan_deg = 32'sd3667;
      5'd11: atan_deg = 32'sd1833;
      5'd12: atan_deg = 32'sd917;
      5'd13: atan_deg = 32'sd458;
      5'd14: atan_deg = 32'sd229;
      5'd15: atan_deg = 32'sd115;
      5'd16: atan_deg = 32'sd57;
      5'd17: atan_deg = 32'sd29;
      default: atan_deg = 32'sd0;
    endcase
  endfunction

endpackage

// ===== sv/am2d_cordic.sv =====
// ----------------------------------------------------------------------------
// am2d_cordic: iterative sine and cosine in degree units
// Reduces the angle in seven compare and subtract steps, then runs one CORDIC
// iteration per cycle.
// ----------------------------------------------------------------------------
module am2d_cordic import am2d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] deg_i,
  output logic               done_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  typedef enum logic [1:0] {C_IDLE, C_RED, C_RUN, C_DONE} cstate_e;

  // The first reduction step removes 64 turns, the last a single turn.
  localparam logic [4:0] RED_TOP = 5'd6;

  cstate_e state_q, state_d;
  logic signed [31:0] r_q, r_d;
  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [31:0] z_q, z_d;
  logic [4:0] i_q, i_d;
  logic negcos_q, negcos_d;
  logic signed [31:0] step, lim, rr, fr;
  logic signed [33:0] xr, yr;

  // Rounds a Q4.30 value to Q16.16 and clamps it to [-1, 1].
  function automatic logic signed [31:0] rnd(input logic signed [33:0] v);
    logic signed [33:0] t;
    begin
      t = (v + 34'sd8192) >>> 14;
      if (t > 34'sd65536) t = 34'sd65536;
      if (t < -34'sd65536) t = -34'sd65536;
      rnd = t[31:0];
    end
  endfunction

  always_comb begin
    state_d = state_q;
    r_d = r_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    i_d = i_q;
    negcos_d = negcos_q;
    step = DEG_360 <<< i_q;
    lim = step - DEG_180;
    rr = r_q;
    fr = r_q;
    xr = x_q >>> i_q;
    yr = y_q >>> i_q;
    case (state_q)
      C_IDLE: if (start_i) begin
        r_d = deg_i;
        i_d = RED_TOP;
        state_d = C_RED;
      end
      C_RED: begin
        // Remove 2^i turns when the angle lies at least that far minus half a
        // turn from zero; after the single-turn step it sits in [-180, 180).
        if (r_q >= lim) begin
          rr = r_q - step;
        end else if (r_q < -lim) begin
          rr = r_q + step;
        end
        r_d = rr;
        i_d = i_q - 5'd1;
        if (i_q == 5'd0) begin
          negcos_d = 1'b0;
          fr = rr;
          if (rr > DEG_90) begin
            fr = DEG_180 - rr;
            negcos_d = 1'b1;
          end else if (rr < -DEG_90) begin
            fr = -DEG_180 - rr;
            negcos_d = 1'b1;
          end
          z_d = fr;
          x_d = CORDIC_GAIN;
          y_d = '0;
          i_d = '0;
          state_d = C_RUN;
        end
      end
      C_RUN: begin
        if (z_q >= 0) begin
          x_d = x_q - yr;
          y_d = y_q + xr;
          z_d = z_q - atan_deg(i_q);
        end else begin
          x_d = x_q + yr;
          y_d = y_q - xr;
          z_d = z_q + atan_deg(i_q);
        end
        i_d = i_q + 5'd1;
        if (i_q == 5'(CORDIC_STEPS - 1)) state_d = C_DONE;
      end
      C_DONE: state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    i_q <= i_d;
    negcos_q <= negcos_d;
  end

  // Sine and cosine are valid during the single done cycle.
  assign done_o = (state_q == C_DONE);
  assign sin_o = rnd(y_q);
  assign cos_o = negcos_q ? -rnd(x_q) : rnd(x_q);

endmodule

// ===== sv/am2d_mac.sv =====
// ----------------------------------------------------------------------------
// am2d_mac: shared Q16.16 multiply with floored truncation
// One 32x32 product per cycle, registered, then shifted by 16.
// ----------------------------------------------------------------------------
module am2d_mac import am2d_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] op_a_i,
  input  logic signed [31:0] op_b_i,
  output logic signed [47:0] prod_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= op_a_i * op_b_i;
  end

  assign prod_o = 48'(p_q >>> 16);

endmodule

// ===== sv/affine_2d_matrix_stack.sv =====
// ----------------------------------------------------------------------------
// affine_2d_matrix_stack: 2D affine transform with a bounded save stack
// Applies push, pop, translate, rotate, scale and reset commands.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals
// in      | input     | in_valid_i, in_stall_o, func_i, arg_x_i, arg_y_i
// out     | output    | out_valid_o, out_stall_i, m_*_o, status_o
//
// One command is taken at a time. A push writes the transform to the stack,
// a pop reads it back, translate and scale run their products through the
// multiplier, and rotate runs seven angle reduction steps, 18 CORDIC steps,
// then eight products through the single shared multiplier. Full push, empty
// pop, reset and unknown commands go straight to the result beat. The block
// is free again in the cycle after the result beat leaves.
// Reset clears the current transform to identity and the stack level to zero.
// A stall on the output holds the result; the input stays stalled meanwhile.
// The stack is one memory, one word written or read per cycle.
// ----------------------------------------------------------------------------
module affine_2d_matrix_stack import am2d_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] arg_x_i,
  input  logic signed [31:0] arg_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] m_a_o,
  output logic signed [31:0] m_b_o,
  output logic signed [31:0] m_c_o,
  output logic signed [31:0] m_d_o,
  output logic signed [31:0] m_tx_o,
  output logic signed [31:0] m_ty_o,
  output logic [1:0]         status_o
);

  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH * 8);

  state_e state_q, state_d;
  logic [2:0] func_q;
  logic signed [31:0] ax_q, ay_q;
  // Current transform: index 0 a, 1 b, 2 c, 3 d, 4 tx, 5 ty.
  logic signed [31:0] m_q [6];
  logic signed [31:0] n_q [6];
  logic [LW-1:0] lvl_q, lvl_d;
  logic [1:0] status_q, status_d;
  logic [3:0] cnt_q, cnt_d;
  logic signed [47:0] acc_q, acc_d;
  logic signed [31:0] sn_q, cs_q;
  logic signed [31:0] mem [STACK_DEPTH * 8];
  logic signed [31:0] rd_q;
  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic cor_start, cor_done;
  logic signed [31:0] cor_sin, cor_cos;
  logic signed [31:0] op_a, op_b;
  logic signed [47:0] prod;
  logic wr_res, ld_new;
  logic [2:0] res_idx;
  logic [LW-1:0] lvl_m1;

  // The angle is taken straight from the input port in the accepting cycle.
  am2d_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start), .deg_i(arg_x_i),
    .done_o(cor_done), .sin_o(cor_sin), .cos_o(cor_cos)
  );

  am2d_mac u_mac (.clk_i, .op_a_i(op_a), .op_b_i(op_b), .prod_o(prod));

  function automatic logic signed [31:0] sat(input logic signed [47:0] v);
    if (v > 48'sh7FFFFFFF) sat = 32'sh7FFFFFFF;
    else if (v < -48'sh80000000) sat = 32'sh80000000;
    else sat = v[31:0];
  endfunction

  assign lvl_m1 = lvl_q - 1'b1;

  // Product schedule: step k picks operands; the product lands in the cycle after.
  // Each result element gathers two products (one for scale).
  always_comb begin
    op_a = m_q[0];
    op_b = ax_q;
    case (func_q)
      FUNC_TRANS: begin
        case (cnt_q)
          4'd0: begin op_a = m_q[0]; op_b = ax_q; end
          4'd1: begin op_a = m_q[2]; op_b = ay_q; end
          4'd2: begin op_a = m_q[1]; op_b = ax_q; end
          default: begin op_a = m_q[3]; op_b = ay_q; end
        endcase
      end
      FUNC_SCALE: begin
        op_a = m_q[cnt_q[1:0]];
        op_b = cnt_q[1] ? ay_q : ax_q;
      end
      default: begin
        // Rotate: a'=a*cs-c*sn, c'=a*sn+c*cs, b'=b*cs-d*sn, d'=b*sn+d*cs.
        case (cnt_q)
          4'd0: begin op_a = m_q[0]; op_b = cs_q; end
          4'd1: begin op_a = m_q[2]; op_b = sn_q; end
          4'd2: begin op_a = m_q[0]; op_b = sn_q; end
          4'd3: begin op_a = m_q[2]; op_b = cs_q; end
          4'd4: begin op_a = m_q[1]; op_b = cs_q; end
          4'd5: begin op_a = m_q[3]; op_b = sn_q; end
          4'd6: begin op_a = m_q[1]; op_b = sn_q; end
          default: begin op_a = m_q[3]; op_b = cs_q; end
        endcase
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    lvl_d = lvl_q;
    status_d = status_q;
    cnt_d = cnt_q;
    cor_start = 1'b0;
    mem_we = 1'b0;
    mem_addr = AW'({lvl_q, 3'b000});
    wr_res = 1'b0;
    res_idx = 3'd0;
    ld_new = 1'b0;
    acc_d = acc_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          status_d = ST_OK;
          case (func_i)
            FUNC_PUSH: begin
              if (lvl_q >= LW'(STACK_DEPTH)) begin
                status_d = ST_PUSH_FULL;
                state_d = S_OUT;
              end else begin
                state_d = S_MEMW;
              end
            end
            FUNC_POP: begin
              if (lvl_q == '0) begin
                status_d = ST_POP_EMPTY;
                state_d = S_OUT;
              end else begin
                lvl_d = lvl_m1;
                state_d = S_MEMR;
              end
            end
            FUNC_TRANS, FUNC_SCALE: state_d = S_MUL;
            FUNC_ROT: begin
              cor_start = 1'b1;
              state_d = S_RED0;
            end
            FUNC_RESET: begin
              lvl_d = '0;
              state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_RED0: if (cor_done) state_d = S_MUL;
      S_MUL: begin
        // cnt_q selects the operands; the registered product of step
        // cnt_q-1 is folded into the accumulator now.
        cnt_d = cnt_q + 4'd1;
        if (cnt_q != 4'd0) begin
          case (func_q)
            FUNC_SCALE: begin
              wr_res = 1'b1;
              res_idx = 3'(cnt_q - 4'd1);
              acc_d = prod;
            end
            FUNC_TRANS: begin
              if (cnt_q[0]) begin
                acc_d = prod;
              end else begin
                acc_d = acc_q + prod + (cnt_q == 4'd2 ? 48'(m_q[4]) : 48'(m_q[5]));
                wr_res = 1'b1;
                res_idx = (cnt_q == 4'd2) ? 3'd4 : 3'd5;
              end
            end
            default: begin
              if (cnt_q[0]) begin
                acc_d = prod;
              end else begin
                wr_res = 1'b1;
                // Steps 2,4,6,8 finish a', c', b', d'.
                case (cnt_q)
                  4'd2: begin res_idx = 3'd0; acc_d = acc_q - prod; end
                  4'd4: begin res_idx = 3'd2; acc_d = acc_q + prod; end
                  4'd6: begin res_idx = 3'd1; acc_d = acc_q - prod; end
                  default: begin res_idx = 3'd3; acc_d = acc_q + prod; end
                endcase
              end
            end
          endcase
        end
        if ((func_q == FUNC_ROT && cnt_q == 4'd8) || (func_q != FUNC_ROT && cnt_q == 4'd4)) begin
          ld_new = 1'b1;
          state_d = S_OUT;
        end
      end
      S_MEMW: begin
        mem_we = 1'b1;
        mem_addr = AW'({lvl_q, cnt_q[2:0]});
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd5) begin
          lvl_d = lvl_q + 1'b1;
          state_d = S_OUT;
        end
      end
      S_MEMR: begin
        mem_addr = AW'({lvl_q, cnt_q[2:0]});
        cnt_d = cnt_q + 4'd1;
        state_d = S_MEMR2;
      end
      S_MEMR2: begin
        // Read data of word cnt_q-1 is registered; issue the next read.
        mem_addr = AW'({lvl_q, cnt_q[2:0]});
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd6) state_d = S_OUT;
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q <= '0;
      status_q <= ST_OK;
      m_q[0] <= Q_ONE;
      m_q[1] <= '0;
      m_q[2] <= '0;
      m_q[3] <= Q_ONE;
      m_q[4] <= '0;
      m_q[5] <= '0;
    end else begin
      state_q <= state_d;
      lvl_q <= lvl_d;
      status_q <= status_d;
      if (state_q == S_IDLE && in_valid_i && func_i == FUNC_RESET) begin
        m_q[0] <= Q_ONE;
        m_q[1] <= '0;
        m_q[2] <= '0;
        m_q[3] <= Q_ONE;
        m_q[4] <= '0;
        m_q[5] <= '0;
      end else if (state_q == S_MEMR2) begin
        m_q[3'(cnt_q - 4'd1)] <= rd_q;
      end else if (ld_new) begin
        for (int k = 0; k < 6; k++) begin
          if (func_q == FUNC_TRANS ? (k >= 4) : (k < 4)) begin
            m_q[k] <= (wr_res && res_idx == 3'(k)) ? sat(acc_d) : n_q[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    if (state_q == S_IDLE && in_valid_i) begin
      func_q <= func_i;
      ax_q <= arg_x_i;
      ay_q <= arg_y_i;
    end
    if (cor_done) begin
      sn_q <= cor_sin;
      cs_q <= cor_cos;
    end
    if (wr_res) n_q[res_idx] <= sat(acc_d);
    if (mem_we) mem[mem_addr] <= m_q[cnt_q[2:0]];
    rd_q <= mem[mem_addr];
  end

  // The final element is written in the same cycle as ld_new, so the last
  // result goes straight from the accumulator.
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign m_a_o = m_q[0];
  assign m_b_o = m_q[1];
  assign m_c_o = m_q[2];
  assign m_d_o = m_q[3];
  assign m_tx_o = m_q[4];
  assign m_ty_o = m_q[5];
  assign status_o = status_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LW'(STACK_DEPTH)) else $error("stack level beyond depth");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE)) else $error("accept lost");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(m_a_o)))
    else $error("result changed under stall");

endmodule
